@@ sv/pal_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pal_pkg: shared types and constants for the positional array list engine
// Store geometry, field widths, request codes and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  // fixed field widths
  localparam int unsigned TW = 3;
  localparam int unsigned PW = 7;
  localparam int unsigned VW = 32;

  // compare width wide enough for both a position and a count plus one
  localparam int unsigned XW = ((CW > PW) ? CW : PW) + 1;

  localparam logic [PW-1:0] MAX_ENTRIES_RESET = PW'(DEPTH);

  typedef enum logic [TW-1:0] {
    REQ_READ   = 3'd0,
    REQ_UPDATE = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_FIND   = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_COUNT,
    IDX_POS,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  typedef enum logic [1:0] {
    ADR_POS_M1,
    ADR_IDX,
    ADR_IDX_M1
  } adr_sel_e;

  typedef enum logic {
    WD_VALUE,
    WD_RDATA
  } wd_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef enum logic [1:0] {
    FD_ZERO,
    FD_RDATA,
    FD_HOLD
  } fd_sel_e;

  typedef struct packed {
    logic     latch;
    idx_op_e  idx_op;
    logic     rd_en;
    adr_sel_e rd_sel;
    logic     wr_en;
    adr_sel_e wr_sel;
    wd_sel_e  wd_sel;
    logic     hold_ld;
    cnt_op_e  cnt_op;
    logic     fin;
    logic     fin_ok;
    fd_sel_e  fin_data;
    logic     fin_fpos;
  } pal_cmd_t;

  typedef struct packed {
    logic [TW-1:0] req_type;
    logic          pos_ok;
    logic          ins_ok;
    logic          idx_ge_pos;
    logic          idx_lt_cnt;
    logic          match;
  } pal_sts_t;

endpackage
`default_nettype wire

@@ sv/pal_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pal_dpath: list datapath
// Entry store, entry count, capacity register, walk pointer, request latch
// and result registers, driven by controller commands.
// ----------------------------------------------------------------------------
module pal_dpath (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire pal_pkg::pal_cmd_t      cmd_i,
  output pal_pkg::pal_sts_t           sts_o,
  input  wire logic                   max_entries_we_i,
  input  wire logic [pal_pkg::PW-1:0] max_entries_i,
  input  wire logic [pal_pkg::TW-1:0] req_type_i,
  input  wire logic [pal_pkg::PW-1:0] position_i,
  input  wire logic [pal_pkg::VW-1:0] value_i,
  output logic                        done_o,
  output logic                        ok_o,
  output logic [pal_pkg::VW-1:0]      data_o,
  output logic [pal_pkg::PW-1:0]      found_position_o,
  output logic [pal_pkg::PW-1:0]      count_o,
  output logic                        is_empty_o,
  output logic                        is_full_o
);

  logic [pal_pkg::VW-1:0] mem [pal_pkg::DEPTH];

  logic [pal_pkg::PW-1:0] max_q;
  logic [pal_pkg::CW-1:0] count_q, count_d;
  logic [pal_pkg::CW-1:0] idx_q, idx_d;
  logic [pal_pkg::TW-1:0] req_q;
  logic [pal_pkg::PW-1:0] pos_q;
  logic [pal_pkg::VW-1:0] val_q;
  logic [pal_pkg::VW-1:0] rdata_q;
  logic [pal_pkg::VW-1:0] hold_q;
  logic                   done_q, ok_q;
  logic [pal_pkg::VW-1:0] data_q;
  logic [pal_pkg::PW-1:0] fpos_q;

  logic [pal_pkg::XW-1:0] pos_x, cnt_x, idx_x, cap_x, max_x;
  logic [pal_pkg::AW-1:0] a_pos_m1, a_idx, a_idx_m1, rd_adr, wr_adr;
  logic [pal_pkg::VW-1:0] wdata, fdata;
  logic [pal_pkg::CW-1:0] idx_m1;

  assign pos_x = pal_pkg::XW'(pos_q);
  assign cnt_x = pal_pkg::XW'(count_q);
  assign idx_x = pal_pkg::XW'(idx_q);
  assign max_x = pal_pkg::XW'(max_q);

  // capacity saturated to 1..DEPTH
  always_comb begin
    if (max_x == '0) begin
      cap_x = pal_pkg::XW'(1);
    end else if (max_x > pal_pkg::XW'(pal_pkg::DEPTH)) begin
      cap_x = pal_pkg::XW'(pal_pkg::DEPTH);
    end else begin
      cap_x = max_x;
    end
  end

  assign sts_o.req_type   = req_q;
  assign sts_o.pos_ok     = (pos_x != '0) && (pos_x <= cnt_x);
  assign sts_o.ins_ok     = (pos_x != '0) && (pos_x <= cnt_x + pal_pkg::XW'(1))
                            && (cnt_x < cap_x);
  assign sts_o.idx_ge_pos = (idx_x >= pos_x);
  assign sts_o.idx_lt_cnt = (idx_q < count_q);
  assign sts_o.match      = (rdata_q == val_q);

  assign idx_m1   = idx_q - pal_pkg::CW'(1);
  assign a_pos_m1 = pal_pkg::AW'(pos_x - pal_pkg::XW'(1));
  assign a_idx    = idx_q[pal_pkg::AW-1:0];
  assign a_idx_m1 = idx_m1[pal_pkg::AW-1:0];

  function automatic logic [pal_pkg::AW-1:0] pick_adr(
    input pal_pkg::adr_sel_e    sel,
    input logic [pal_pkg::AW-1:0] p,
    input logic [pal_pkg::AW-1:0] i,
    input logic [pal_pkg::AW-1:0] im1
  );
    logic [pal_pkg::AW-1:0] r;
    case (sel)
      pal_pkg::ADR_POS_M1: r = p;
      pal_pkg::ADR_IDX:    r = i;
      pal_pkg::ADR_IDX_M1: r = im1;
      default:             r = i;
    endcase
    return r;
  endfunction

  assign rd_adr = pick_adr(cmd_i.rd_sel, a_pos_m1, a_idx, a_idx_m1);
  assign wr_adr = pick_adr(cmd_i.wr_sel, a_pos_m1, a_idx, a_idx_m1);
  assign wdata  = (cmd_i.wd_sel == pal_pkg::WD_RDATA) ? rdata_q : val_q;

  always_comb begin
    case (cmd_i.idx_op)
      pal_pkg::IDX_COUNT: idx_d = count_q;
      pal_pkg::IDX_POS:   idx_d = pal_pkg::CW'(pos_x);
      pal_pkg::IDX_ZERO:  idx_d = '0;
      pal_pkg::IDX_INC:   idx_d = idx_q + pal_pkg::CW'(1);
      pal_pkg::IDX_DEC:   idx_d = idx_m1;
      default:            idx_d = idx_q;
    endcase
  end

  always_comb begin
    case (cmd_i.cnt_op)
      pal_pkg::CNT_INC: count_d = count_q + pal_pkg::CW'(1);
      pal_pkg::CNT_DEC: count_d = count_q - pal_pkg::CW'(1);
      default:          count_d = count_q;
    endcase
  end

  always_comb begin
    case (cmd_i.fin_data)
      pal_pkg::FD_RDATA: fdata = rdata_q;
      pal_pkg::FD_HOLD:  fdata = hold_q;
      default:           fdata = '0;
    endcase
  end

  // store: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_adr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_adr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= pal_pkg::MAX_ENTRIES_RESET;
      count_q <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      if (max_entries_we_i) begin
        max_q <= max_entries_i;
      end
      count_q <= count_d;
      idx_q   <= idx_d;
      done_q  <= cmd_i.fin;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_type_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (cmd_i.hold_ld) begin
      hold_q <= rdata_q;
    end
    if (cmd_i.fin) begin
      ok_q   <= cmd_i.fin_ok;
      data_q <= cmd_i.fin_ok ? fdata : '0;
      fpos_q <= (cmd_i.fin_ok && cmd_i.fin_fpos) ?
                pal_pkg::PW'(idx_q + pal_pkg::CW'(1)) : '0;
    end
  end

  assign done_o           = done_q;
  assign ok_o             = ok_q;
  assign data_o           = data_q;
  assign found_position_o = fpos_q;
  assign count_o          = pal_pkg::PW'(count_q);
  assign is_empty_o       = (count_q == '0);
  assign is_full_o        = (cnt_x >= cap_x);

endmodule
`default_nettype wire

@@ sv/pal_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pal_ctrl: request sequencer
// Decodes a latched request and walks the store one entry per read/write
// pair for insert and remove, and one entry per read/compare pair for find.
// ----------------------------------------------------------------------------
module pal_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire pal_pkg::pal_sts_t sts_i,
  output pal_pkg::pal_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_READ_OUT,
    S_INS_LOOP,
    S_INS_WR,
    S_REM_HOLD,
    S_REM_LOOP,
    S_REM_WR,
    S_FIND_LOOP,
    S_FIND_CMP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.idx_op   = pal_pkg::IDX_HOLD;
    cmd_o.rd_sel   = pal_pkg::ADR_IDX;
    cmd_o.wr_sel   = pal_pkg::ADR_IDX;
    cmd_o.wd_sel   = pal_pkg::WD_VALUE;
    cmd_o.cnt_op   = pal_pkg::CNT_HOLD;
    cmd_o.fin_data = pal_pkg::FD_ZERO;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        case (sts_i.req_type)
          pal_pkg::REQ_READ: begin
            if (sts_i.pos_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = pal_pkg::ADR_POS_M1;
              state_d      = S_READ_OUT;
            end else begin
              cmd_o.fin = 1'b1;
            end
          end
          pal_pkg::REQ_UPDATE: begin
            cmd_o.fin = 1'b1;
            if (sts_i.pos_ok) begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wr_sel = pal_pkg::ADR_POS_M1;
              cmd_o.fin_ok = 1'b1;
            end
          end
          pal_pkg::REQ_INSERT: begin
            if (sts_i.ins_ok) begin
              cmd_o.idx_op = pal_pkg::IDX_COUNT;
              state_d      = S_INS_LOOP;
            end else begin
              cmd_o.fin = 1'b1;
            end
          end
          pal_pkg::REQ_REMOVE: begin
            if (sts_i.pos_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = pal_pkg::ADR_POS_M1;
              cmd_o.idx_op = pal_pkg::IDX_POS;
              state_d      = S_REM_HOLD;
            end else begin
              cmd_o.fin = 1'b1;
            end
          end
          pal_pkg::REQ_FIND: begin
            cmd_o.idx_op = pal_pkg::IDX_ZERO;
            state_d      = S_FIND_LOOP;
          end
          default: begin
            cmd_o.fin = 1'b1;
          end
        endcase
      end
      S_READ_OUT: begin
        cmd_o.fin      = 1'b1;
        cmd_o.fin_ok   = 1'b1;
        cmd_o.fin_data = pal_pkg::FD_RDATA;
        state_d        = S_IDLE;
      end
      S_INS_LOOP: begin
        if (sts_i.idx_ge_pos) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = pal_pkg::ADR_IDX_M1;
          state_d      = S_INS_WR;
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.cnt_op = pal_pkg::CNT_INC;
          cmd_o.fin    = 1'b1;
          cmd_o.fin_ok = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wd_sel = pal_pkg::WD_RDATA;
        cmd_o.idx_op = pal_pkg::IDX_DEC;
        state_d      = S_INS_LOOP;
      end
      S_REM_HOLD: begin
        cmd_o.hold_ld = 1'b1;
        state_d       = S_REM_LOOP;
      end
      S_REM_LOOP: begin
        if (sts_i.idx_lt_cnt) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_REM_WR;
        end else begin
          cmd_o.cnt_op   = pal_pkg::CNT_DEC;
          cmd_o.fin      = 1'b1;
          cmd_o.fin_ok   = 1'b1;
          cmd_o.fin_data = pal_pkg::FD_HOLD;
          state_d        = S_IDLE;
        end
      end
      S_REM_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = pal_pkg::ADR_IDX_M1;
        cmd_o.wd_sel = pal_pkg::WD_RDATA;
        cmd_o.idx_op = pal_pkg::IDX_INC;
        state_d      = S_REM_LOOP;
      end
      S_FIND_LOOP: begin
        if (sts_i.idx_lt_cnt) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_FIND_CMP;
        end else begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_FIND_CMP: begin
        if (sts_i.match) begin
          cmd_o.fin      = 1'b1;
          cmd_o.fin_ok   = 1'b1;
          cmd_o.fin_fpos = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.idx_op = pal_pkg::IDX_INC;
          state_d      = S_FIND_LOOP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

@@ sv/positional_array_list_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// positional_array_list_engine: ordered list of signed 32-bit values
// Read, update, insert, remove and find by 1-based position in a 64-entry
// store, one request per item, one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_type_i, position_i, value_i and raise start;
//   the item is taken at a clock edge with start high and busy low. busy
//   stays high until the result is registered.
//   Result channel: done_o is high for exactly one cycle with ok_o, data_o,
//   found_position_o, count_o, is_empty_o and is_full_o. The receiver has
//   no stall; a new item may be started in the done_o cycle.
//   Capacity: max_entries_we_i writes max_entries_i (0 acts as 1, values
//   above the store depth act as the depth). Write it only while idle.
// Sequence per item: every item is decoded after it is taken; update and
//   any failed check finish at decode, and read adds one registered store
//   read. Insert, remove and find then walk the store entry by entry, each
//   step a store read followed by a write-back or compare, since the
//   registered store read must land first. The slowest item is a find that
//   misses on a full 64-entry list.
// Reset: the list is empty and the capacity is 64; store contents are not
//   cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_array_list_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [6:0]  position_i,
  input  wire logic [31:0] value_i,
  // capacity register
  input  wire logic        max_entries_we_i,
  input  wire logic [6:0]  max_entries_i,
  // result channel
  output logic             done_o,
  output logic             ok_o,
  output logic [31:0]      data_o,
  output logic [6:0]       found_position_o,
  output logic [6:0]       count_o,
  output logic             is_empty_o,
  output logic             is_full_o
);

  // command and status between sequencer and datapath
  pal_pkg::pal_cmd_t cmd;
  pal_pkg::pal_sts_t sts;

  // sequencer: decode, then shift/search walks
  pal_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // datapath: store, count, capacity, result registers
  pal_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .max_entries_we_i (max_entries_we_i),
    .max_entries_i    (max_entries_i),
    .req_type_i       (req_type_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .done_o           (done_o),
    .ok_o             (ok_o),
    .data_o           (data_o),
    .found_position_o (found_position_o),
    .count_o          (count_o),
    .is_empty_o       (is_empty_o),
    .is_full_o        (is_full_o)
  );

endmodule
`default_nettype wire

@@ tb/sv/positional_array_list_engine_test.sv @@
// ----------------------------------------------------------------------------
// positional_array_list_engine_test: self-checking bench for the list engine
// Drives read, update, insert, remove and find items through the start/busy
// handshake, predicts each result from a private copy of the list and the
// capacity, and compares every done_o result field by field, in order.
// ----------------------------------------------------------------------------
module positional_array_list_engine_test;

  // request codes past the last defined one; the block must reject them
  localparam logic [pal_pkg::TW-1:0] REQ_UNKNOWN_FIRST = 3'd5;
  localparam logic [pal_pkg::TW-1:0] REQ_UNKNOWN_MID   = 3'd6;
  localparam logic [pal_pkg::TW-1:0] REQ_CODE_LAST     = 3'd7;
  localparam logic [pal_pkg::PW-1:0] POS_ALL_ONES      = 7'd127;

  typedef struct packed {
    logic                   ok;
    logic [pal_pkg::VW-1:0] data;
    logic [pal_pkg::PW-1:0] fpos;
    logic [pal_pkg::PW-1:0] count;
    logic                   empty;
    logic                   full;
  } list_result_t;

  // clock, reset and block inputs, all known from time zero
  logic                   clk_i            = 1'b0;
  logic                   rst_ni           = 1'b0;
  logic                   start            = 1'b0;
  logic [pal_pkg::TW-1:0] req_type_i       = '0;
  logic [pal_pkg::PW-1:0] position_i       = '0;
  logic [pal_pkg::VW-1:0] value_i          = '0;
  logic                   max_entries_we_i = 1'b0;
  logic [pal_pkg::PW-1:0] max_entries_i    = '0;

  logic                   busy;
  logic                   done_o;
  logic                   ok_o;
  logic [pal_pkg::VW-1:0] data_o;
  logic [pal_pkg::PW-1:0] found_position_o;
  logic [pal_pkg::PW-1:0] count_o;
  logic                   is_empty_o;
  logic                   is_full_o;

  positional_array_list_engine u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .max_entries_we_i (max_entries_we_i),
    .max_entries_i    (max_entries_i),
    .done_o           (done_o),
    .ok_o             (ok_o),
    .data_o           (data_o),
    .found_position_o (found_position_o),
    .count_o          (count_o),
    .is_empty_o       (is_empty_o),
    .is_full_o        (is_full_o)
  );

  // shadow of the list: entries above list_len are never looked at
  logic [pal_pkg::VW-1:0] list_vals [pal_pkg::DEPTH];
  int                     list_len = 0;
  logic [pal_pkg::PW-1:0] cap_reg  = pal_pkg::MAX_ENTRIES_RESET;

  list_result_t  pending_results [$];
  list_result_t  oldest_result;

  int mismatch_cnt  = 0;
  int results_seen  = 0;
  int items_sent    = 0;
  int peak_len      = 0;
  int idle_pct      = 0;   // sender idle chance per cycle, in percent

  logic [pal_pkg::VW-1:0] corner_vals [5] = '{32'h8000_0000, 32'h7FFF_FFFF,
                                              32'hFFFF_FFFF, 32'h0000_0000,
                                              32'h0000_0001};

  // 4-unit clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Apply one accepted request to the shadow list and return what the block
  // must report for it. Capacity register saturates to 1..DEPTH.
  function automatic list_result_t apply_request(logic [pal_pkg::TW-1:0] req,
                                                 logic [pal_pkg::PW-1:0] pos,
                                                 logic [pal_pkg::VW-1:0] val);
    list_result_t r;
    int p;
    int cap;
    int i;
    r   = '0;
    p   = pos;
    cap = cap_reg;
    if (cap < 1) cap = 1;
    if (cap > int'(pal_pkg::DEPTH)) cap = int'(pal_pkg::DEPTH);
    case (req)
      pal_pkg::REQ_READ: begin
        if (p >= 1 && p <= list_len) begin
          r.data = list_vals[p-1];
          r.ok   = 1'b1;
        end
      end
      pal_pkg::REQ_UPDATE: begin
        if (p >= 1 && p <= list_len) begin
          list_vals[p-1] = val;
          r.ok           = 1'b1;
        end
      end
      pal_pkg::REQ_INSERT: begin
        // full list or a gap in the positions: nothing moves
        if (p >= 1 && p <= list_len + 1 && list_len < cap) begin
          for (i = list_len; i >= p; i--) list_vals[i] = list_vals[i-1];
          list_vals[p-1] = val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      pal_pkg::REQ_REMOVE: begin
        if (p >= 1 && p <= list_len) begin
          r.data = list_vals[p-1];
          for (i = p; i < list_len; i++) list_vals[i-1] = list_vals[i];
          list_len--;
          r.ok = 1'b1;
        end
      end
      pal_pkg::REQ_FIND: begin
        // first match wins; data stays zero even on a hit
        for (i = 0; i < list_len; i++) begin
          if (list_vals[i] == val) begin
            r.fpos = pal_pkg::PW'(i + 1);
            r.ok   = 1'b1;
            break;
          end
        end
      end
      default: ;  // unknown code: only the status fields are reported
    endcase
    r.count = pal_pkg::PW'(list_len);
    r.empty = (list_len == 0);
    r.full  = (list_len >= cap);
    return r;
  endfunction

  // Present one item, hold it until the block takes it, then maybe idle.
  // start is left high when no gap follows, so back-to-back items never
  // see it drop.
  task automatic issue_request(logic [pal_pkg::TW-1:0] req, logic [pal_pkg::PW-1:0] pos,
                               logic [pal_pkg::VW-1:0] val);
    @(negedge clk_i);
    start      <= 1'b1;
    req_type_i <= req;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(apply_request(req, pos, val));
    items_sent++;
    if (list_len > peak_len) peak_len = list_len;
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    end
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Capacity is only written with the block idle.
  task automatic write_capacity(logic [pal_pkg::PW-1:0] cap);
    drain_results();
    max_entries_we_i <= 1'b1;
    max_entries_i    <= cap;
    @(negedge clk_i);
    max_entries_we_i <= 1'b0;
    cap_reg = cap;
  endtask

  // Empty list right after reset: every positional request fails, find
  // misses, and the undefined codes report only status.
  task automatic test_reset_state();
    issue_request(pal_pkg::REQ_READ,   7'd1, 32'h0);
    issue_request(pal_pkg::REQ_UPDATE, 7'd1, 32'h1234_5678);
    issue_request(pal_pkg::REQ_REMOVE, 7'd1, 32'h0);
    issue_request(pal_pkg::REQ_FIND,   7'd0, 32'h0);
    issue_request(REQ_UNKNOWN_FIRST, POS_ALL_ONES, 32'hFFFF_FFFF);
    issue_request(REQ_UNKNOWN_MID,   7'd1, 32'h0);
    issue_request(REQ_CODE_LAST,     7'd0, 32'h8000_0000);
  endtask

  // Value and position extremes, first-match find, and a stored -1 that
  // must come back with ok set.
  task automatic test_edge_values();
    issue_request(pal_pkg::REQ_INSERT, 7'd1, 32'hFFFF_FFFF);
    issue_request(pal_pkg::REQ_INSERT, 7'd2, 32'h8000_0000);
    issue_request(pal_pkg::REQ_INSERT, 7'd1, 32'h7FFF_FFFF);
    issue_request(pal_pkg::REQ_INSERT, 7'd4, 32'h0000_0000);    // append at count+1
    issue_request(pal_pkg::REQ_INSERT, 7'd6, 32'h5555_5555);    // past count+1
    issue_request(pal_pkg::REQ_INSERT, 7'd0, 32'h5555_5555);
    issue_request(pal_pkg::REQ_INSERT, POS_ALL_ONES, 32'hAAAA_AAAA);
    issue_request(pal_pkg::REQ_READ,   7'd1, 32'h0);
    issue_request(pal_pkg::REQ_READ,   7'd4, 32'h0);
    issue_request(pal_pkg::REQ_READ,   7'd5, 32'h0);
    issue_request(pal_pkg::REQ_READ,   7'd0, 32'h0);
    issue_request(pal_pkg::REQ_READ,   7'd2, 32'h0);            // stored -1
    issue_request(pal_pkg::REQ_UPDATE, 7'd3, 32'hFFFF_FFFF);    // duplicate -1
    issue_request(pal_pkg::REQ_FIND,   7'd0, 32'hFFFF_FFFF);    // first of two
    issue_request(pal_pkg::REQ_FIND,   7'd0, 32'h1234_5678);    // miss
    issue_request(pal_pkg::REQ_REMOVE, 7'd2, 32'h0);
    issue_request(pal_pkg::REQ_REMOVE, 7'd3, 32'h0);            // last entry
    issue_request(pal_pkg::REQ_REMOVE, 7'd65, 32'h0);
    issue_request(pal_pkg::REQ_UPDATE, POS_ALL_ONES, 32'h0);
    issue_request(pal_pkg::REQ_FIND,   7'd0, 32'hFFFF_FFFF);
  endtask

  // Capacity below the count, capacity 1, 0 acting as 1, 127 acting as 64.
  task automatic test_capacity_limits();
    write_capacity(7'd1);                // two entries held, cap 1
    issue_request(pal_pkg::REQ_INSERT, 7'd1, 32'h1111_1111);
    issue_request(pal_pkg::REQ_REMOVE, 7'd1, 32'h0);
    issue_request(pal_pkg::REQ_REMOVE, 7'd1, 32'h0);
    issue_request(pal_pkg::REQ_INSERT, 7'd1, 32'h2222_2222);
    issue_request(pal_pkg::REQ_INSERT, 7'd2, 32'h3333_3333);    // full
    write_capacity(7'd0);
    issue_request(pal_pkg::REQ_INSERT, 7'd1, 32'h4444_4444);
    write_capacity(POS_ALL_ONES);
    issue_request(pal_pkg::REQ_INSERT, 7'd1, 32'h4444_4444);
  endtask

  // Random mix: mostly legal positions so the list grows and shifts deeply,
  // with some bad positions and undefined codes. grow_pct sets the share of
  // inserts; removes are weighted double among the rest.
  task automatic test_random_mix(int n_items, int gap_pct, int grow_pct);
    logic [pal_pkg::TW-1:0] req;
    logic [pal_pkg::PW-1:0] pos;
    logic [pal_pkg::VW-1:0] val;
    int roll;
    int hi;
    idle_pct = gap_pct;
    repeat (n_items) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        req = pal_pkg::TW'($urandom_range(REQ_CODE_LAST, REQ_UNKNOWN_FIRST));
      end else if (roll < 3 + grow_pct) begin
        req = pal_pkg::REQ_INSERT;
      end else begin
        case ($urandom_range(4))
          0:       req = pal_pkg::REQ_READ;
          1:       req = pal_pkg::REQ_UPDATE;
          2, 3:    req = pal_pkg::REQ_REMOVE;
          default: req = pal_pkg::REQ_FIND;
        endcase
      end
      hi   = (req == pal_pkg::REQ_INSERT) ? list_len + 1 : list_len;
      roll = $urandom_range(99);
      if (roll < 85 && hi >= 1) pos = pal_pkg::PW'($urandom_range(hi, 1));
      else if (roll < 93)       pos = pal_pkg::PW'(hi + 1);
      else                      pos = pal_pkg::PW'($urandom_range(127));
      roll = $urandom_range(99);
      if (roll < 40 && list_len > 0) val = list_vals[$urandom_range(list_len - 1)];
      else if (roll < 55)            val = corner_vals[$urandom_range(4)];
      else                           val = $urandom;
      issue_request(req, pos, val);
      // now and then let the pipe run dry before continuing
      if ($urandom_range(99) == 0) drain_results();
    end
  endtask

  // Result checker: each done_o cycle is matched against the oldest
  // prediction. Sampled at the rising edge, before the block updates.
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result with none expected, expected nothing, actual data %0h",
                 $time, data_o);
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("ok",             32'(oldest_result.ok),    32'(ok_o));
        check_field("data",           oldest_result.data,       data_o);
        check_field("found_position", 32'(oldest_result.fpos),  32'(found_position_o));
        check_field("count",          32'(oldest_result.count), 32'(count_o));
        check_field("is_empty",       32'(oldest_result.empty), 32'(is_empty_o));
        check_field("is_full",        32'(oldest_result.full),  32'(is_full_o));
      end
    end
  end

  // Stimulus sequence
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_edge_values();
    test_capacity_limits();

    test_random_mix(300, 0, 45);        // no idling, list grows
    write_capacity(7'd64);
    test_random_mix(250, 87, 70);       // sparse items, fill to the top
    write_capacity(7'd5);               // well below the current count
    test_random_mix(250, 30, 5);        // shrink back under the capacity
    write_capacity(7'd16);
    test_random_mix(250, 87, 50);
    write_capacity(7'd1);
    test_random_mix(100, 0, 50);
    write_capacity(POS_ALL_ONES);
    test_random_mix(300, 30, 50);

    drain_results();
    repeat (20) @(posedge clk_i);

    $display("covered %0d items and %0d results; list peaked at %0d entries,",
             items_sent, results_seen, peak_len);
    $display("capacity went through 0, 1, 5, 16, 64 and 127 with idle sender phases");
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("positional_array_list_engine_test: clean");
    end else begin
      $display("positional_array_list_engine_test: errors");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #6000000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("positional_array_list_engine_test: errors");
    $finish;
  end

endmodule
